// ===== hw/rtl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/olt_pkg.sv =====
// ============================================================================
// olt_pkg
// Shared constants, codes and types of the ordered list table engine.
// ============================================================================
package olt_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 9;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 8;
  localparam int COUNT_W  = 9;

  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam int IN_W     = CMD_W + VAL_W + POS_W;
  localparam int IN_BYTES = (IN_W + 7) / 8;
  localparam int OUT_W    = STATUS_W + FOUND_W + COUNT_W + 3 * VAL_W;
  localparam int OUT_BYTES = (OUT_W + 7) / 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_AT    = 3'd3,
    CMD_FIND      = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Control from the sequencer to the aggregate unit.
  typedef struct packed {
    logic             clear;
    logic             sample;
    logic             find_en;
    logic [VAL_W-1:0] key;
    logic [CNT_W-1:0] idx;
  } agg_ctrl_t;

endpackage

// ===== hw/rtl/olt_ram.sv =====
// ============================================================================
// olt_ram
// Single-port synchronous RAM with registered read data.
// ============================================================================
module olt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/olt_agg.sv =====
// ============================================================================
// olt_agg
// Running sum, minimum, maximum and first-match search over a memory sweep.
// ============================================================================
module olt_agg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  olt_pkg::agg_ctrl_t       ctrl_i,
  input  logic [olt_pkg::VAL_W-1:0] data_i,
  output logic [olt_pkg::VAL_W-1:0] total_o,
  output logic [olt_pkg::VAL_W-1:0] smallest_o,
  output logic [olt_pkg::VAL_W-1:0] largest_o,
  output logic                     hit_o,
  output logic [olt_pkg::CNT_W-1:0] hit_idx_o
);
  import olt_pkg::*;

  logic [VAL_W-1:0]        sum_q, sum_d;
  logic signed [VAL_W-1:0] lo_q, lo_d, hi_q, hi_d, din;
  logic                    have_q, have_d, hit_q, hit_d;
  logic [CNT_W-1:0]        hit_idx_q, hit_idx_d;

  assign din = data_i;

  always_comb begin
    sum_d     = sum_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    have_d    = have_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    if (ctrl_i.clear) begin
      sum_d     = '0;
      lo_d      = '0;
      hi_d      = '0;
      have_d    = 1'b0;
      hit_d     = 1'b0;
      hit_idx_d = '0;
    end else if (ctrl_i.sample) begin
      sum_d  = sum_q + data_i;
      have_d = 1'b1;
      if (!have_q || (din < lo_q)) begin
        lo_d = din;
      end
      if (!have_q || (din > hi_q)) begin
        hi_d = din;
      end
      // keep the first match only
      if (ctrl_i.find_en && !hit_q && (data_i == ctrl_i.key)) begin
        hit_d     = 1'b1;
        hit_idx_d = ctrl_i.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      have_q <= have_d;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    hit_idx_q <= hit_idx_d;
  end

  assign total_o    = sum_q;
  assign smallest_o = lo_q;
  assign largest_o  = hi_q;
  assign hit_o      = hit_q;
  assign hit_idx_o  = hit_idx_q;

endmodule

// ===== hw/rtl/ordered_list_table_engine.sv =====
// ============================================================================
// ordered_list_table_engine
// Bounded ordered list of signed 32-bit values kept in one single-port RAM.
// ============================================================================
// The list lives in positions 0..count-1 of a 256-entry single-port RAM with
// registered read data. One request is worked at a time; s_axis_tready is
// high only while the sequencer is idle, and a finished result waits in the
// output register so the next request can be taken before it is drained.
// An insert moves every entry from the insert position to the end up by one,
// a delete moves every entry after the position down by one; each move is a
// read and then a write on the RAM port, and an insert then writes the new
// value. After that, one sweep reads all entries, one per cycle, to form the
// sum, minimum, maximum and (for a find) the first matching index. The RAM
// needs no clearing: only entries below count are ever read. Errors (full,
// empty, bad position, not found) leave the list untouched and still report
// the aggregates of the current contents.
module ordered_list_table_engine (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // request: cmd[2:0], value[34:3], position[43:35], zero fill [47:44]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [olt_pkg::IN_BYTES*8-1:0]       s_axis_tdata,
  // result: status[2:0], found_index[10:3], entry_count[19:11],
  //         total[51:20], smallest[83:52], largest[115:84], zero fill [119:116]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [olt_pkg::OUT_BYTES*8-1:0]      m_axis_tdata
);
  import olt_pkg::*;

`include "assert_macros.svh"

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SHIFT_RD = 6'b000010,
    S_SHIFT_WR = 6'b000100,
    S_PUT      = 6'b001000,
    S_SCAN     = 6'b010000,
    S_FINISH   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] pend_idx_q, pend_idx_d;
  logic             pend_q, pend_d;
  logic             is_ins_q, is_ins_d;
  logic             find_q, find_d;
  status_e          status_q, status_d;
  logic [VAL_W-1:0] value_q, value_d;

  logic                   m_valid_q, m_valid_d;
  logic [OUT_BYTES*8-1:0] m_data_q, m_data_d;

  // request fields
  logic [CMD_W-1:0] in_cmd;
  logic [VAL_W-1:0] in_value;
  logic [POS_W-1:0] in_pos;
  logic             accept;

  // RAM port
  logic             ram_re, ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  // aggregate unit
  agg_ctrl_t        agg_ctrl;
  logic [VAL_W-1:0] agg_total, agg_smallest, agg_largest;
  logic             agg_hit;
  logic [CNT_W-1:0] agg_hit_idx;

  // wide compare operands
  logic [CMP_W-1:0] ins_pos_w, cnt_w;
  logic [CNT_W:0]   idx_p2, cnt_p1;

  logic    load_out;
  status_e fin_status;

  assign in_cmd   = s_axis_tdata[CMD_W-1:0];
  assign in_value = s_axis_tdata[CMD_W+VAL_W-1:CMD_W];
  assign in_pos   = s_axis_tdata[CMD_W+VAL_W+POS_W-1:CMD_W+VAL_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cnt_w  = CMP_W'(count_q);
  assign idx_p2 = (CNT_W+1)'(idx_q) + (CNT_W+1)'(2);
  assign cnt_p1 = (CNT_W+1)'(count_q);

  // insert position by command
  always_comb begin
    unique case (in_cmd)
      CMD_INS_FRONT: ins_pos_w = '0;
      CMD_INS_BACK:  ins_pos_w = cnt_w;
      default:       ins_pos_w = CMP_W'(in_pos);
    endcase
  end

  // find status is settled once the sweep is over
  always_comb begin
    fin_status = status_q;
    if (find_q && !agg_hit) begin
      fin_status = ST_NOTFOUND;
    end
  end

  assign load_out = (state_q == S_FINISH) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    is_ins_d   = is_ins_q;
    find_d     = find_q;
    status_d   = status_q;
    value_d    = value_q;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = idx_q[IDX_W-1:0];
    ram_wdata  = ram_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          value_d  = in_value;
          status_d = ST_OK;
          find_d   = 1'b0;
          idx_d    = '0;
          state_d  = S_SCAN;
          unique case (in_cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
              is_ins_d = 1'b1;
              if (count_q == CNT_W'(CAPACITY)) begin
                status_d = ST_FULL;
              end else if (ins_pos_w > cnt_w) begin
                status_d = ST_BADPOS;
              end else if (ins_pos_w == cnt_w) begin
                pos_d   = ins_pos_w[CNT_W-1:0];
                state_d = S_PUT;
              end else begin
                pos_d   = ins_pos_w[CNT_W-1:0];
                idx_d   = count_q;
                state_d = S_SHIFT_RD;
              end
            end
            CMD_DEL_AT: begin
              is_ins_d = 1'b0;
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (CMP_W'(in_pos) >= cnt_w) begin
                status_d = ST_BADPOS;
              end else if (CMP_W'(in_pos) + CMP_W'(1) < cnt_w) begin
                pos_d   = in_pos[CNT_W-1:0];
                idx_d   = in_pos[CNT_W-1:0];
                state_d = S_SHIFT_RD;
              end else begin
                // last entry: just drop it
                count_d = count_q - CNT_W'(1);
              end
            end
            CMD_FIND: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                find_d = 1'b1;
              end
            end
            default: begin
              // unused codes: report the list as is
            end
          endcase
        end
      end

      S_SHIFT_RD: begin
        ram_re   = 1'b1;
        ram_addr = is_ins_q ? IDX_W'(idx_q - CNT_W'(1)) : IDX_W'(idx_q + CNT_W'(1));
        state_d  = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (is_ins_q) begin
          idx_d = idx_q - CNT_W'(1);
          if (idx_q - CNT_W'(1) == pos_q) begin
            state_d = S_PUT;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else begin
          idx_d = idx_q + CNT_W'(1);
          if (idx_p2 < cnt_p1) begin
            state_d = S_SHIFT_RD;
          end else begin
            count_d = count_q - CNT_W'(1);
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_addr  = pos_q[IDX_W-1:0];
        ram_wdata = value_q;
        count_d   = count_q + CNT_W'(1);
        idx_d     = '0;
        state_d   = S_SCAN;
      end

      S_SCAN: begin
        if (idx_q != count_q) begin
          ram_re     = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
          idx_d      = idx_q + CNT_W'(1);
        end else if (!pend_q) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register: hold until taken
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (load_out) begin
      m_valid_d = 1'b1;
      m_data_d  = {
        (OUT_BYTES*8-OUT_W)'(0),
        agg_largest,
        agg_smallest,
        agg_total,
        COUNT_W'(count_q),
        (agg_hit ? FOUND_W'(agg_hit_idx) : FOUND_W'(0)),
        fin_status
      };
    end
  end

  assign agg_ctrl.clear   = accept;
  assign agg_ctrl.sample  = pend_q;
  assign agg_ctrl.find_en = find_q;
  assign agg_ctrl.key     = value_q;
  assign agg_ctrl.idx     = pend_idx_q;

  olt_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(VAL_W)
  ) u_ram (
    .clk_i  (clk_i),
    .re_i   (ram_re),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  olt_agg u_agg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (agg_ctrl),
    .data_i    (ram_rdata),
    .total_o   (agg_total),
    .smallest_o(agg_smallest),
    .largest_o (agg_largest),
    .hit_o     (agg_hit),
    .hit_idx_o (agg_hit_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      find_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      find_q    <= find_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    pend_idx_q <= pend_idx_d;
    is_ins_q   <= is_ins_d;
    status_q   <= status_d;
    value_q    <= value_d;
    m_data_q   <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // list never grows past the RAM
  `ASSERT_IMPLIES(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(CAPACITY))
  // an insert shift always stays above the insert position
  `ASSERT_IMPLIES(a_ins_shift_above, clk_i, rst_ni,
                  (state_q == S_SHIFT_WR) && is_ins_q, idx_q > pos_q)
  // the sweep has drained before the result is formed
  `ASSERT_IMPLIES(a_sweep_drained, clk_i, rst_ni, state_q == S_FINISH, !pend_q)
  // a loaded result is visible in the next cycle
  `ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, load_out, m_axis_tvalid)

endmodule

// ===== verif/ordered_list_table_engine_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ordered_list_table_engine_tb
// Self-checking stream testbench for the ordered list table engine.
// ============================================================================
// A generator fills a backlog of requests up front. It starts with a short
// directed sequence: empty list, bad positions, value extremes, unused
// commands. Random phases follow. They churn the list around a drifting
// target size, and once they fill it to capacity and drain it again. A
// driver offers the backlog in bursts with random gaps. Each accepted request
// is run through a queue-based model of the list. The model yields the one
// result that the request causes. A monitor compares each drained result
// field by field with the oldest pending prediction. The receiver stalls on
// its own rotating pattern. Once it holds off for a long stretch, so that
// the engine backs up and stalls its input.
module ordered_list_table_engine_tb;
  import olt_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  // Worst request: two RAM passes over a full list plus the aggregate sweep.
  localparam int DRAIN_CYCLES = 2 * CAPACITY + CAPACITY + 100;
  localparam int HOLD_CYCLES  = 3000;
  localparam int HOLD_AFTER   = 40;
  localparam int PRINT_LIMIT  = 50;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_W'(CMD_FIND + 1);
  // Value planted at the back of a nearly full list, found again at index 255.
  localparam logic [VAL_W-1:0] MARK_VALUE = 32'h1357_9BDF;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } olt_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found;
    logic [COUNT_W-1:0]  cnt;
    logic [VAL_W-1:0]    total;
    logic [VAL_W-1:0]    smallest;
    logic [VAL_W-1:0]    largest;
  } olt_res_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // request: cmd[2:0], value[34:3], position[43:35], zero fill [47:44]
  logic [IN_BYTES*8-1:0]   s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // result: status[2:0], found_index[10:3], entry_count[19:11],
  //         total[51:20], smallest[83:52], largest[115:84], zero fill [119:116]
  logic [OUT_BYTES*8-1:0]  m_axis_tdata;

  olt_req_t       req_backlog[$];   // requests not yet accepted, oldest first
  olt_res_t       due_results[$];   // predicted results not yet drained
  logic [VAL_W-1:0] list_model[$];  // list contents, position 0 first

  int plan_n         = 0;  // list size as the generator expects it
  int issued_n       = 0;
  int mismatch_count = 0;
  int results_seen   = 0;

  bit          req_open    = 1'b0;
  int          burst_left  = 0;
  int          gap_left    = 0;
  int          hold_left   = 0;
  bit          hold_done   = 1'b0;
  int          stall_age   = 0;
  logic [15:0] stall_pattern = '1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  ordered_list_table_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // --------------------------------------------------------------------------
  // List model: apply one request, then report status and aggregates
  // --------------------------------------------------------------------------
  task automatic apply_to_list(input olt_req_t r, output olt_res_t e);
    int n;
    int p;
    logic [VAL_W-1:0]        sum;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    n        = list_model.size();
    e.status = ST_OK;
    e.found  = '0;
    case (r.cmd)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        p = (r.cmd == CMD_INS_FRONT) ? 0 : (r.cmd == CMD_INS_BACK) ? n : int'(r.pos);
        // A full list wins over a bad position.
        if (n >= CAPACITY) e.status = ST_FULL;
        else if (p > n) e.status = ST_BADPOS;
        else list_model.insert(p, r.value);
      end
      CMD_DEL_AT: begin
        if (n == 0) e.status = ST_EMPTY;
        else if (int'(r.pos) >= n) e.status = ST_BADPOS;
        else list_model.delete(int'(r.pos));
      end
      CMD_FIND: begin
        if (n == 0) e.status = ST_EMPTY;
        else begin
          e.status = ST_NOTFOUND;
          // Stop at the first match.
          for (int i = 0; i < n && e.status != ST_OK; i++) begin
            if (list_model[i] == r.value) begin
              e.status = ST_OK;
              e.found  = 8'(i);
            end
          end
        end
      end
      default: ;  // spare codes leave the list alone and still report
    endcase

    sum = '0;
    lo  = '0;
    hi  = '0;
    if (list_model.size() > 0) begin
      lo = list_model[0];
      hi = list_model[0];
    end
    foreach (list_model[i]) begin
      sum += list_model[i];
      if ($signed(list_model[i]) < lo) lo = list_model[i];
      if ($signed(list_model[i]) > hi) hi = list_model[i];
    end
    e.cnt      = 9'(list_model.size());
    e.total    = sum;
    e.smallest = lo;
    e.largest  = hi;
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Predict at the edge where the request is taken.
  always @(posedge clk_i) begin
    olt_res_t due;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      apply_to_list(req_backlog.pop_front(), due);
      due_results.push_back(due);
      req_open = 1'b0;
    end
  end

  // Offer the backlog in bursts and hold an open request until it is taken.
  always @(negedge clk_i) begin
    int draw;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!req_open) begin
      if (gap_left > 0 || req_backlog.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tdata  <= {{(IN_BYTES*8-IN_W){1'b0}}, req_backlog[0].pos,
                          req_backlog[0].value, req_backlog[0].cmd};
        s_axis_tvalid <= 1'b1;
        req_open = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          draw       = $urandom_range(0, 9);
          if (draw < 4) gap_left = 0;
          else if (draw < 8) gap_left = $urandom_range(1, 8);
          else gap_left = $urandom_range(9, 300);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    olt_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = due_results.pop_front();
        check_field("status",      32'(m_axis_tdata[2:0]),    32'(want.status));
        check_field("found_index", 32'(m_axis_tdata[10:3]),   32'(want.found));
        check_field("entry_count", 32'(m_axis_tdata[19:11]),  32'(want.cnt));
        check_field("total",       m_axis_tdata[51:20],       want.total);
        check_field("smallest",    m_axis_tdata[83:52],       want.smallest);
        check_field("largest",     m_axis_tdata[115:84],      want.largest);
      end
      results_seen++;
    end
  end

  // Stall on a rotating pattern, redrawn now and then; hold off once for long.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_age == 0) begin
        stall_age     = $urandom_range(16, 96);
        stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
        if (stall_pattern == '0) stall_pattern = 16'h0001;
      end
      stall_age--;
      m_axis_tready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Queue a request and track the list size it should leave behind.
  task automatic add_req(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] value,
                         logic [POS_W-1:0] pos);
    olt_req_t r;
    r.cmd   = cmd;
    r.value = value;
    r.pos   = pos;
    req_backlog.push_back(r);
    issued_n++;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: if (plan_n < CAPACITY) plan_n++;
      CMD_INS_AT: if (plan_n < CAPACITY && int'(pos) <= plan_n) plan_n++;
      CMD_DEL_AT: if (plan_n > 0 && int'(pos) < plan_n) plan_n--;
      default: ;
    endcase
  endtask

  // Extremes, a small pool that repeats (so finds hit), or any pattern.
  function automatic logic [VAL_W-1:0] pick_value();
    int draw;
    draw = $urandom_range(0, 9);
    if (draw == 0) return 32'h8000_0000;
    if (draw == 1) return 32'h7FFF_FFFF;
    if (draw == 2) return '0;
    if (draw == 3) return '1;
    if (draw < 7) return 32'($signed($urandom_range(0, 16)) - 8);
    return $urandom;
  endfunction

  initial begin
    int  first_random;
    int  target;
    int  span;
    int  draw;
    bit  grow;
    bit  filled;

    // Directed: empty list, bad positions, extremes, every command.
    add_req(CMD_FIND,      32'h0000_0000, 9'd0);
    add_req(CMD_DEL_AT,    32'h0000_0000, 9'd0);
    add_req(CMD_INS_AT,    32'h7FFF_FFFF, 9'd1);
    add_req(CMD_INS_AT,    32'h7FFF_FFFF, 9'd0);
    add_req(CMD_INS_FRONT, 32'h8000_0000, 9'h1FF);
    add_req(CMD_INS_BACK,  32'hFFFF_FFFF, 9'd0);
    add_req(CMD_INS_BACK,  32'h0000_0000, 9'd0);
    add_req(CMD_INS_AT,    32'h0000_0005, 9'd2);
    add_req(CMD_INS_AT,    32'h7FFF_FFFF, 9'd5);   // insert at the very end
    add_req(CMD_INS_AT,    32'h0000_0009, 9'd256);
    add_req(CMD_INS_AT,    32'h0000_0009, 9'h1FF);
    add_req(CMD_FIND,      32'h7FFF_FFFF, 9'd0);   // duplicate: first one wins
    add_req(CMD_FIND,      32'h0000_1234, 9'd0);
    for (int c = CMD_SPARE_FIRST; c < 2**CMD_W; c++)
      add_req(c[CMD_W-1:0], 32'hFFFF_FFFF, 9'h1FF);
    add_req(CMD_DEL_AT,    32'h0000_0000, 9'd6);
    add_req(CMD_DEL_AT,    32'h0000_0000, 9'd300);
    add_req(CMD_DEL_AT,    32'h0000_0000, 9'd0);
    add_req(CMD_DEL_AT,    32'h0000_0000, 9'd4);
    add_req(CMD_DEL_AT,    32'h0000_0000, 9'd1);
    add_req(CMD_FIND,      32'hFFFF_FFFF, 9'd0);

    first_random = issued_n;
    filled       = 1'b0;
    while (issued_n < first_random + RANDOM_ITEMS) begin
      if (!filled && issued_n >= first_random + RANDOM_ITEMS / 3) begin
        // Fill to capacity, poke the full list, then drain back down.
        filled = 1'b1;
        while (plan_n < CAPACITY) begin
          if (plan_n == CAPACITY - 1) begin
            add_req(CMD_INS_BACK, MARK_VALUE, 9'($urandom));
          end else begin
            draw = $urandom_range(0, 3);
            if (draw == 0) add_req(CMD_INS_FRONT, pick_value(), 9'($urandom));
            else if (draw == 1) add_req(CMD_INS_AT, pick_value(), 9'($urandom_range(0, plan_n)));
            else add_req(CMD_INS_BACK, pick_value(), 9'($urandom));
          end
        end
        add_req(CMD_INS_FRONT, pick_value(), 9'($urandom));
        add_req(CMD_INS_BACK,  pick_value(), 9'($urandom));
        add_req(CMD_INS_AT,    pick_value(), 9'(CAPACITY));
        add_req(CMD_INS_AT,    pick_value(), 9'd300);
        add_req(CMD_FIND,      MARK_VALUE,   9'($urandom));
        add_req(CMD_FIND,      pick_value(), 9'($urandom));
        add_req(CMD_DEL_AT,    pick_value(), 9'(CAPACITY));
        add_req(CMD_DEL_AT,    pick_value(), 9'(CAPACITY - 1));
        add_req(CMD_FIND,      MARK_VALUE,   9'($urandom));
        while (plan_n > 16) begin
          if ($urandom_range(0, 4) == 0) add_req(CMD_FIND, pick_value(), 9'($urandom));
          else add_req(CMD_DEL_AT, pick_value(), 9'($urandom_range(0, plan_n - 1)));
        end
      end else begin
        // Churn around a target size; mostly small lists keep requests short.
        draw = $urandom_range(0, 9);
        if (draw == 0) target = 0;
        else if (draw < 7) target = $urandom_range(1, 12);
        else target = $urandom_range(13, 64);
        span = $urandom_range(20, 80);
        repeat (span) begin
          draw = $urandom_range(0, 99);
          if (draw < 6) begin
            add_req(3'($urandom), $urandom, 9'($urandom));
          end else if (draw < 26) begin
            add_req(CMD_FIND, pick_value(), 9'($urandom));
          end else begin
            grow = (plan_n < target) ? ($urandom_range(0, 4) != 0)
                                     : ($urandom_range(0, 4) == 0);
            if (grow) begin
              draw = $urandom_range(0, 2);
              if (draw == 0) add_req(CMD_INS_FRONT, pick_value(), 9'($urandom));
              else if (draw == 1) add_req(CMD_INS_BACK, pick_value(), 9'($urandom));
              else add_req(CMD_INS_AT, pick_value(), 9'($urandom_range(0, plan_n)));
            end else if (plan_n == 0) begin
              add_req(CMD_DEL_AT, pick_value(), 9'd0);
            end else begin
              add_req(CMD_DEL_AT, pick_value(), 9'($urandom_range(0, plan_n - 1)));
            end
          end
        end
      end
    end

    // Wait for every request to be taken and every result to drain.
    while (req_backlog.size() != 0 || due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #60_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== ordered_list_table_engine.f =====
+incdir+hw/rtl
hw/rtl/olt_pkg.sv
hw/rtl/olt_ram.sv
hw/rtl/olt_agg.sv
hw/rtl/ordered_list_table_engine.sv
verif/ordered_list_table_engine_tb.sv
